>>> hdl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
package spq_pkg;

    // Field widths of one request word and one response word
    localparam int KEY_W   = 16;
    localparam int ID_W    = 8;
    localparam int PAY_W   = 3 * ID_W;
    localparam int COUNT_W = 5;

    // Request codes
    typedef enum logic {
        REQ_PUSH = 1'b0,
        REQ_POP  = 1'b1
    } t_req;

    // Response status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;   // capture the accepted request word
        logic exec;   // carry out the captured request, load the response
    } t_cmd;

endpackage

>>> hdl/spq_req_if.sv
// Request channel: valid/ready handshake carrying one push or pop word.
interface spq_req_if;
    import spq_pkg::*;

    logic             valid;
    logic             ready;
    logic             req_type;
    logic [KEY_W-1:0] new_key;
    logic [ID_W-1:0]  new_pickup;
    logic [ID_W-1:0]  new_dropoff;
    logic [ID_W-1:0]  new_kind;

    modport source (
        output valid, req_type, new_key, new_pickup, new_dropoff, new_kind,
        input  ready
    );

    modport sink (
        input  valid, req_type, new_key, new_pickup, new_dropoff, new_kind,
        output ready
    );
endinterface

>>> hdl/spq_rsp_if.sv
// Response channel: valid/ready handshake carrying one result word.
interface spq_rsp_if;
    import spq_pkg::*;

    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [KEY_W-1:0]   out_key;
    logic [ID_W-1:0]    out_pickup;
    logic [ID_W-1:0]    out_dropoff;
    logic [ID_W-1:0]    out_kind;
    logic [COUNT_W-1:0] entry_count;

    modport source (
        output valid, status, out_key, out_pickup, out_dropoff, out_kind, entry_count,
        input  ready
    );

    modport sink (
        input  valid, status, out_key, out_pickup, out_dropoff, out_kind, entry_count,
        output ready
    );
endinterface

>>> hdl/spq_ctrl.sv
// Controller: sequences capture and execution, owns the handshakes.
module spq_ctrl
    import spq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_rsp_valid, n_rsp_valid;
    logic   w_out_free;

    // response register can take a new word this cycle
    assign w_out_free = !r_rsp_valid || i_rsp_ready;

    // next state and commands
    always_comb begin
        n_state     = r_state;
        n_rsp_valid = r_rsp_valid;
        o_cmd       = '0;
        if (r_rsp_valid && i_rsp_ready) begin
            n_rsp_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_out_free) begin
                    o_cmd.exec  = 1'b1;
                    n_rsp_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_rsp_valid;

endmodule

>>> hdl/spq_dp.sv
// Datapath: sorted row of key/payload cells, occupancy count, response register.
module spq_dp
    import spq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic               i_req_type,
    input  logic [KEY_W-1:0]   i_new_key,
    input  logic [PAY_W-1:0]   i_new_pay,
    output logic [1:0]         o_status,
    output logic [KEY_W-1:0]   o_key,
    output logic [PAY_W-1:0]   o_pay,
    output logic [COUNT_W-1:0] o_count
);

    localparam int CW = $clog2(DEPTH + 1);

    // captured request
    logic             r_req_type;
    logic [KEY_W-1:0] r_new_key;
    logic [PAY_W-1:0] r_new_pay;

    // cell row, slot 0 holds the smallest key
    logic [KEY_W-1:0] r_key [DEPTH];
    logic [PAY_W-1:0] r_pay [DEPTH];
    logic [CW-1:0]    r_count, n_count;

    // response register
    t_status          r_status, n_status;
    logic [KEY_W-1:0] r_out_key, n_out_key;
    logic [PAY_W-1:0] r_out_pay, n_out_pay;

    logic             w_full, w_empty, w_push, w_pop;
    logic [DEPTH-1:0] w_stay;

    assign w_full  = (r_count == CW'(DEPTH));
    assign w_empty = (r_count == '0);
    assign w_push  = i_cmd.exec && (r_req_type == REQ_PUSH) && !w_full;
    assign w_pop   = i_cmd.exec && (r_req_type == REQ_POP) && !w_empty;

    // per-cell compare: occupied and key not above the new key keeps its place
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_stay[i] = (CW'(i) < r_count) && (r_key[i] <= r_new_key);
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req_type <= i_req_type;
            r_new_key  <= i_new_key;
            r_new_pay  <= i_new_pay;
        end
    end

    // cell row: insert on push, shift towards slot 0 on pop
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DEPTH; i++) begin
            if (w_push && !w_stay[i]) begin
                if (i == 0) begin
                    r_key[i] <= r_new_key;
                    r_pay[i] <= r_new_pay;
                end else if (w_stay[(i == 0) ? 0 : i - 1]) begin
                    r_key[i] <= r_new_key;
                    r_pay[i] <= r_new_pay;
                end else begin
                    r_key[i] <= r_key[(i == 0) ? 0 : i - 1];
                    r_pay[i] <= r_pay[(i == 0) ? 0 : i - 1];
                end
            end else if (w_pop && (i < DEPTH - 1)) begin
                r_key[i] <= r_key[(i < DEPTH - 1) ? i + 1 : i];
                r_pay[i] <= r_pay[(i < DEPTH - 1) ? i + 1 : i];
            end
        end
    end

    // count and response word
    always_comb begin
        n_count   = r_count;
        n_status  = r_status;
        n_out_key = r_out_key;
        n_out_pay = r_out_pay;
        if (i_cmd.exec) begin
            n_status  = ST_OK;
            n_out_key = '0;
            n_out_pay = '0;
            if (r_req_type == REQ_PUSH) begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end else begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_out_key = r_key[0];
                    n_out_pay = r_pay[0];
                    n_count   = r_count - CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status  <= n_status;
        r_out_key <= n_out_key;
        r_out_pay <= n_out_pay;
    end

    assign o_status = r_status;
    assign o_key    = r_out_key;
    assign o_pay    = r_out_pay;
    assign o_count  = COUNT_W'(r_count);

endmodule

>>> hdl/sorted_priority_queue_unit.sv
// Sorted priority queue: top level joining controller and datapath.
//
// Usage:
//   i_req carries one request word: push (key plus pickup, dropoff and
//   type payload) or pop of the smallest key. Equal keys leave in arrival
//   order. o_rsp returns exactly one word per request: a status (ok, push
//   rejected as full, pop rejected as empty), the popped entry (zero on
//   pushes and rejected pops) and the number of entries left stored.
//   Sequence: an accepted word is captured into the request register and
//   executed in the execute state once the response register is free;
//   its response is then registered and shown on o_rsp.valid.
//   Pacing: one request at a time, none accepted while one executes; the
//   cell row compares all stored keys with the new key at once and inserts
//   or shifts in the execute state; the capture/execute pair sets the rate.
//   Stall: a waiting response sits in the output register; the next
//   request is still accepted and held until that response is taken.
//   Reset: synchronous, active low. The queue comes up empty; no clearing
//   pass is needed and requests are taken from the first cycle after reset.
module sorted_priority_queue_unit
    import spq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    spq_req_if.sink    i_req,
    spq_rsp_if.source  o_rsp
);

    t_cmd             w_cmd;
    logic [PAY_W-1:0] w_out_pay;

    // sequencer
    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .o_cmd       (w_cmd)
    );

    // cell row and response register
    spq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_req_type (i_req.req_type),
        .i_new_key  (i_req.new_key),
        .i_new_pay  ({i_req.new_pickup, i_req.new_dropoff, i_req.new_kind}),
        .o_status   (o_rsp.status),
        .o_key      (o_rsp.out_key),
        .o_pay      (w_out_pay),
        .o_count    (o_rsp.entry_count)
    );

    assign o_rsp.out_pickup  = w_out_pay[3*ID_W-1:2*ID_W];
    assign o_rsp.out_dropoff = w_out_pay[2*ID_W-1:ID_W];
    assign o_rsp.out_kind    = w_out_pay[ID_W-1:0];

    // one request in flight: no acceptance right after an acceptance
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request accepted while previous one still executing");

    // a rejected push reports a full queue
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status == ST_FULL) |-> o_rsp.entry_count == COUNT_W'(DEPTH))
        else $error("push rejected with queue not full");

    // a rejected pop reports an empty queue
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status == ST_EMPTY) |-> o_rsp.entry_count == '0)
        else $error("pop rejected with queue not empty");

    // rejected results carry a zero entry
    a_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status != ST_OK) |->
            (o_rsp.out_key == '0 && w_out_pay == '0))
        else $error("rejected request returned a non-zero entry");

endmodule
